@@ design/nnds_pkg.sv @@
package nnds_pkg;

    // Field widths of the pixel words
    localparam int PIX_W  = 16;
    localparam int DEST_W = 8;

    // Configuration register widths
    localparam int SRC_CFG_W = 12;
    localparam int DST_CFG_W = 8;

    // Default limits for the top-level parameters
    localparam int MAX_DST_WIDTH_DEF  = 240;
    localparam int MAX_DST_HEIGHT_DEF = 240;
    localparam int MAX_SRC_SIZE_DEF   = 2048;

    // Register reset values
    localparam logic [SRC_CFG_W-1:0] SRC_WIDTH_RST  = 12'd320;
    localparam logic [SRC_CFG_W-1:0] SRC_HEIGHT_RST = 12'd240;
    localparam logic [DST_CFG_W-1:0] DST_WIDTH_RST  = 8'd240;
    localparam logic [DST_CFG_W-1:0] DST_HEIGHT_RST = 8'd240;
    localparam logic                 SWAP_BYTES_RST = 1'b1;

    // APB port geometry: five 32-bit registers at 4-byte steps
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    // Register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SWAP_BYTES = 3'd4;

endpackage

@@ design/nnds_in_if.sv @@
interface nnds_in_if;

    logic                        valid;
    logic                        ready;
    logic [nnds_pkg::PIX_W-1:0]  src_pixel;
    logic                        frame_start;

    modport source (output valid, output src_pixel, output frame_start, input ready);
    modport sink   (input valid, input src_pixel, input frame_start, output ready);

endinterface

@@ design/nnds_out_if.sv @@
interface nnds_out_if;

    logic                        valid;
    logic                        ready;
    logic [nnds_pkg::PIX_W-1:0]  out_pixel;
    logic [nnds_pkg::DEST_W-1:0] dest_x;
    logic [nnds_pkg::DEST_W-1:0] dest_y;
    logic                        frame_end;

    modport source (output valid, output out_pixel, output dest_x, output dest_y,
                    output frame_end, input ready);
    modport sink   (input valid, input out_pixel, input dest_x, input dest_y,
                    input frame_end, output ready);

endinterface

@@ design/nearest_neighbor_frame_downscaler_core.sv @@
// Channel    | Dir | Word                                         | Handshake
// -----------+-----+----------------------------------------------+------------
// pixel_in   | in  | src_pixel, frame_start                       | valid/ready
// pixel_out  | out | out_pixel, dest_x, dest_y, frame_end         | valid/ready
// APB        | in  | psel/penable/pwrite/paddr/pwdata -> prdata   | pready = 1
//
// One source word per cycle sustained while pixel_out is not stalled and the maps are
// built; a selected pixel passes the stage register (read of the column and row
// maps) and the output register before it shows on pixel_out. After reset and
// after each write to a size register, the two map builders walk their RAMs
// with pixel_in not ready; swap_bytes writes take effect at once.
// Output stalls back up through one stage register into pixel_in.ready.
module nearest_neighbor_frame_downscaler_core #(
    parameter int MAX_DST_WIDTH  = nnds_pkg::MAX_DST_WIDTH_DEF,
    parameter int MAX_DST_HEIGHT = nnds_pkg::MAX_DST_HEIGHT_DEF,
    parameter int MAX_SRC_SIZE   = nnds_pkg::MAX_SRC_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nnds_pkg::PADDR_W-1:0]  paddr,
    input  logic [nnds_pkg::PDATA_W-1:0]  pwdata,
    output logic [nnds_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    nnds_in_if.sink                       pixel_in,
    nnds_out_if.source                    pixel_out
);

    localparam int SZ_W  = $clog2(MAX_SRC_SIZE + 1);
    localparam int POS_W = $clog2(MAX_SRC_SIZE);
    localparam int DW_W  = $clog2(MAX_DST_WIDTH + 1);
    localparam int DH_W  = $clog2(MAX_DST_HEIGHT + 1);

    typedef struct packed {
        logic [nnds_pkg::PIX_W-1:0] pixel;
        logic                       frame_start;
        logic [POS_W-1:0]           col;
        logic [POS_W-1:0]           row;
        logic                       col_oob;
        logic                       row_oob;
        logic                       line_end;
        logic                       frame_wrap;
    } s2_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [nnds_pkg::SRC_CFG_W-1:0] src_width_reg, src_height_reg;
    logic [nnds_pkg::DST_CFG_W-1:0] dst_width_reg, dst_height_reg;
    logic                           swap_bytes_reg;
    logic [nnds_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_wr;
    logic                           size_wr;
    logic                           start_reg;

    assign reg_idx = paddr[nnds_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (reg_idx)
            nnds_pkg::REG_SRC_WIDTH,
            nnds_pkg::REG_SRC_HEIGHT,
            nnds_pkg::REG_DST_WIDTH,
            nnds_pkg::REG_DST_HEIGHT: size_wr = cfg_wr;
            default:                  size_wr = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= nnds_pkg::SRC_WIDTH_RST;
            src_height_reg <= nnds_pkg::SRC_HEIGHT_RST;
            dst_width_reg  <= nnds_pkg::DST_WIDTH_RST;
            dst_height_reg <= nnds_pkg::DST_HEIGHT_RST;
            swap_bytes_reg <= nnds_pkg::SWAP_BYTES_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                nnds_pkg::REG_SRC_WIDTH:  src_width_reg  <= pwdata[nnds_pkg::SRC_CFG_W-1:0];
                nnds_pkg::REG_SRC_HEIGHT: src_height_reg <= pwdata[nnds_pkg::SRC_CFG_W-1:0];
                nnds_pkg::REG_DST_WIDTH:  dst_width_reg  <= pwdata[nnds_pkg::DST_CFG_W-1:0];
                nnds_pkg::REG_DST_HEIGHT: dst_height_reg <= pwdata[nnds_pkg::DST_CFG_W-1:0];
                nnds_pkg::REG_SWAP_BYTES: swap_bytes_reg <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (reg_idx)
            nnds_pkg::REG_SRC_WIDTH:  prdata = nnds_pkg::PDATA_W'(src_width_reg);
            nnds_pkg::REG_SRC_HEIGHT: prdata = nnds_pkg::PDATA_W'(src_height_reg);
            nnds_pkg::REG_DST_WIDTH:  prdata = nnds_pkg::PDATA_W'(dst_width_reg);
            nnds_pkg::REG_DST_HEIGHT: prdata = nnds_pkg::PDATA_W'(dst_height_reg);
            nnds_pkg::REG_SWAP_BYTES: prdata = nnds_pkg::PDATA_W'(swap_bytes_reg);
            default:                  prdata = '0;
        endcase
    end

    // Map rebuild request: once out of reset, then after each size write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b1;
        end
        else
        begin
            start_reg <= size_wr;
        end
    end

    // ------------------------------------------------------------------
    // Effective sizes: zero acts as one, large values saturate
    // ------------------------------------------------------------------
    logic [SZ_W-1:0] w_eff, h_eff;
    logic [DW_W-1:0] dw_eff;
    logic [DH_W-1:0] dh_eff;

    always_comb
    begin
        if (src_width_reg == '0)
            w_eff = SZ_W'(1);
        else if (32'(src_width_reg) > 32'(MAX_SRC_SIZE))
            w_eff = SZ_W'(MAX_SRC_SIZE);
        else
            w_eff = SZ_W'(src_width_reg);

        if (src_height_reg == '0)
            h_eff = SZ_W'(1);
        else if (32'(src_height_reg) > 32'(MAX_SRC_SIZE))
            h_eff = SZ_W'(MAX_SRC_SIZE);
        else
            h_eff = SZ_W'(src_height_reg);

        if (dst_width_reg == '0)
            dw_eff = DW_W'(1);
        else if (32'(dst_width_reg) > 32'(MAX_DST_WIDTH))
            dw_eff = DW_W'(MAX_DST_WIDTH);
        else
            dw_eff = DW_W'(dst_width_reg);

        if (dst_height_reg == '0)
            dh_eff = DH_W'(1);
        else if (32'(dst_height_reg) > 32'(MAX_DST_HEIGHT))
            dh_eff = DH_W'(MAX_DST_HEIGHT);
        else
            dh_eff = DH_W'(dst_height_reg);
    end

    // ------------------------------------------------------------------
    // Stage 1: source position, map reads
    // ------------------------------------------------------------------
    logic             col_busy, row_busy;
    logic             maps_ready;
    logic             in_acc;
    logic             adv;
    logic             s2_valid_reg;
    s2_t              s2_reg, s2_next;
    logic [POS_W-1:0] src_col_reg, src_col_next;
    logic [POS_W-1:0] src_row_reg, src_row_next;
    logic [POS_W-1:0] cur_col, cur_row;
    logic             row_last;
    logic             out_valid_reg;

    assign maps_ready     = !start_reg && !col_busy && !row_busy;
    assign adv            = !out_valid_reg || pixel_out.ready;
    assign pixel_in.ready = maps_ready && (!s2_valid_reg || adv);
    assign in_acc         = pixel_in.valid && pixel_in.ready;

    always_comb
    begin
        cur_col  = pixel_in.frame_start ? '0 : src_col_reg;
        cur_row  = pixel_in.frame_start ? '0 : src_row_reg;
        row_last = SZ_W'(cur_row) >= (h_eff - SZ_W'(1));

        s2_next.pixel       = pixel_in.src_pixel;
        s2_next.frame_start = pixel_in.frame_start;
        s2_next.col         = cur_col;
        s2_next.row         = cur_row;
        s2_next.col_oob     = SZ_W'(cur_col) >= w_eff;
        s2_next.row_oob     = SZ_W'(cur_row) >= h_eff;
        s2_next.line_end    = SZ_W'(cur_col) >= (w_eff - SZ_W'(1));
        s2_next.frame_wrap  = s2_next.line_end && row_last;

        src_col_next = cur_col + 1'b1;
        src_row_next = cur_row;
        if (s2_next.line_end)
        begin
            src_col_next = '0;
            src_row_next = row_last ? '0 : cur_row + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            s2_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            src_col_reg  <= src_col_next;
            src_row_reg  <= src_row_next;
            s2_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s2_reg <= s2_next;
        end
    end

    logic [DW_W-1:0]  col_rd_dst;
    logic [POS_W-1:0] col_rd_sel;
    logic [DH_W-1:0]  row_rd_dst;
    logic [POS_W-1:0] row_rd_sel;

    nnds_map #(
        .SRC_MAX (MAX_SRC_SIZE),
        .DST_MAX (MAX_DST_WIDTH)
    ) u_col_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .src_size (w_eff),
        .dst_size (dw_eff),
        .busy     (col_busy),
        .rd_en    (in_acc),
        .rd_addr  (cur_col),
        .rd_dst   (col_rd_dst),
        .rd_sel   (col_rd_sel)
    );

    nnds_map #(
        .SRC_MAX (MAX_SRC_SIZE),
        .DST_MAX (MAX_DST_HEIGHT)
    ) u_row_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .src_size (h_eff),
        .dst_size (dh_eff),
        .busy     (row_busy),
        .rd_en    (in_acc),
        .rd_addr  (cur_row),
        .rd_dst   (row_rd_dst),
        .rd_sel   (row_rd_sel)
    );

    // ------------------------------------------------------------------
    // Stage 2: hit test and selection update
    // ------------------------------------------------------------------
    logic [DW_W-1:0]  nd_col_reg, nd_col_next, ndc;
    logic [POS_W-1:0] ns_col_reg, ns_col_next, nsc;
    logic [DH_W-1:0]  nd_row_reg, nd_row_next, ndr;
    logic [POS_W-1:0] ns_row_reg, ns_row_next, nsr;
    logic [DW_W-1:0]  col_d;
    logic [POS_W-1:0] col_s;
    logic [DH_W-1:0]  row_d;
    logic [POS_W-1:0] row_s;
    logic             row_hit, col_hit, hit;
    logic             s2_go;
    logic             frame_end;
    logic [nnds_pkg::PIX_W-1:0] pix_sel;

    assign s2_go = s2_valid_reg && adv;

    always_comb
    begin
        // Frame start clears selection before the test
        ndc = s2_reg.frame_start ? '0 : nd_col_reg;
        nsc = s2_reg.frame_start ? '0 : ns_col_reg;
        ndr = s2_reg.frame_start ? '0 : nd_row_reg;
        nsr = s2_reg.frame_start ? '0 : ns_row_reg;

        // Past the configured size the map is fixed: destination index equals the destination size
        col_d = s2_reg.col_oob ? dw_eff : col_rd_dst;
        col_s = s2_reg.col_oob ? POS_W'(w_eff) : col_rd_sel;
        row_d = s2_reg.row_oob ? dh_eff : row_rd_dst;
        row_s = s2_reg.row_oob ? POS_W'(h_eff) : row_rd_sel;

        row_hit   = (ndr < dh_eff) && (s2_reg.row == nsr);
        col_hit   = (ndc < dw_eff) && (s2_reg.col == nsc);
        hit       = row_hit && col_hit;
        frame_end = (col_d >= dw_eff) && (row_d >= dh_eff);

        nd_col_next = ndc;
        ns_col_next = nsc;
        nd_row_next = ndr;
        ns_row_next = nsr;
        if (hit)
        begin
            nd_col_next = col_d;
            ns_col_next = col_s;
        end
        if (s2_reg.line_end)
        begin
            nd_col_next = '0;
            ns_col_next = '0;
            if (row_hit)
            begin
                nd_row_next = row_d;
                ns_row_next = row_s;
            end
        end
        if (s2_reg.frame_wrap)
        begin
            nd_row_next = '0;
            ns_row_next = '0;
        end

        pix_sel = swap_bytes_reg ? {s2_reg.pixel[7:0], s2_reg.pixel[15:8]} : s2_reg.pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nd_col_reg <= '0;
            ns_col_reg <= '0;
            nd_row_reg <= '0;
            ns_row_reg <= '0;
        end
        else if (s2_go)
        begin
            nd_col_reg <= nd_col_next;
            ns_col_reg <= ns_col_next;
            nd_row_reg <= nd_row_next;
            ns_row_reg <= ns_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [nnds_pkg::PIX_W-1:0]  out_pixel_reg;
    logic [nnds_pkg::DEST_W-1:0] dest_x_reg, dest_y_reg;
    logic                        frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s2_valid_reg && hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go && hit)
        begin
            out_pixel_reg <= pix_sel;
            dest_x_reg    <= nnds_pkg::DEST_W'(ndc);
            dest_y_reg    <= nnds_pkg::DEST_W'(ndr);
            frame_end_reg <= frame_end;
        end
    end

    assign pixel_out.valid     = out_valid_reg;
    assign pixel_out.out_pixel = out_pixel_reg;
    assign pixel_out.dest_x    = dest_x_reg;
    assign pixel_out.dest_y    = dest_y_reg;
    assign pixel_out.frame_end = frame_end_reg;

endmodule

@@ design/nnds_ram.sv @@
module nnds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/nnds_map.sv @@
// Builds and serves the selection map of one axis. Entry c holds, for a hit
// at source index c, the next destination index d = ceil((c+1)*dst/src) and
// its source index floor(d*src/dst). Built by a two-pointer walk that only
// adds and compares; one pointer step or one RAM write per cycle.
module nnds_map #(
    parameter int SRC_MAX = nnds_pkg::MAX_SRC_SIZE_DEF,
    parameter int DST_MAX = nnds_pkg::MAX_DST_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [$clog2(SRC_MAX+1)-1:0] src_size,
    input  logic [$clog2(DST_MAX+1)-1:0] dst_size,
    output logic                         busy,
    input  logic                         rd_en,
    input  logic [$clog2(SRC_MAX)-1:0]   rd_addr,
    output logic [$clog2(DST_MAX+1)-1:0] rd_dst,
    output logic [$clog2(SRC_MAX)-1:0]   rd_sel
);

    localparam int SZ_W   = $clog2(SRC_MAX + 1);
    localparam int DST_W  = $clog2(DST_MAX + 1);
    localparam int POS_W  = $clog2(SRC_MAX);
    localparam int PROD_W = SZ_W + DST_W;
    localparam int WORD_W = DST_W + POS_W;

    typedef enum logic [1:0] {
        MAP_IDLE  = 2'b01,
        MAP_BUILD = 2'b10
    } map_state_t;

    map_state_t          state_reg, state_next;
    logic [DST_W-1:0]    x_reg, x_next;     // destination pointer
    logic [PROD_W-1:0]   a_reg, a_next;     // x * src
    logic [PROD_W-1:0]   b_reg, b_next;     // (c+1) * dst
    logic [SZ_W-1:0]     m_reg, m_next;     // floor(x*src/dst)
    logic [PROD_W-1:0]   mm_reg, mm_next;   // m * dst
    logic [POS_W-1:0]    c_reg, c_next;     // entry being built
    logic [PROD_W:0]     sum_m;
    logic                step_x;
    logic                step_m;
    logic                last_c;
    logic                wr_en;
    logic [WORD_W-1:0]   wr_data;
    logic [WORD_W-1:0]   rd_data;

    // Walk control
    always_comb
    begin
        sum_m  = {1'b0, mm_reg} + (PROD_W+1)'(dst_size);
        step_x = a_reg < b_reg;
        step_m = !step_x && (sum_m <= {1'b0, a_reg});
        last_c = SZ_W'(c_reg) == (src_size - SZ_W'(1));
        wr_en  = (state_reg == MAP_BUILD) && !step_x && !step_m;

        state_next = state_reg;
        x_next     = x_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        m_next     = m_reg;
        mm_next    = mm_reg;
        c_next     = c_reg;

        unique case (state_reg)
            MAP_IDLE:
            begin
                state_next = MAP_IDLE;
            end
            MAP_BUILD:
            begin
                if (step_x)
                begin
                    x_next = x_reg + 1'b1;
                    a_next = a_reg + PROD_W'(src_size);
                end
                else if (step_m)
                begin
                    m_next  = m_reg + 1'b1;
                    mm_next = sum_m[PROD_W-1:0];
                end
                else if (last_c)
                begin
                    state_next = MAP_IDLE;
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                    b_next = b_reg + PROD_W'(dst_size);
                end
            end
            default:
            begin
                state_next = MAP_IDLE;
            end
        endcase

        // A new size restarts the walk from entry zero
        if (start)
        begin
            state_next = MAP_BUILD;
            x_next     = '0;
            a_next     = '0;
            b_next     = PROD_W'(dst_size);
            m_next     = '0;
            mm_next    = '0;
            c_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MAP_IDLE;
            x_reg     <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            m_reg     <= '0;
            mm_reg    <= '0;
            c_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            m_reg     <= m_next;
            mm_reg    <= mm_next;
            c_reg     <= c_next;
        end
    end

    // Source index is kept modulo the position range
    assign wr_data = {x_reg, m_reg[POS_W-1:0]};
    assign busy    = (state_reg == MAP_BUILD);

    nnds_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SRC_MAX)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (c_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_dst = rd_data[WORD_W-1:POS_W];
    assign rd_sel = rd_data[POS_W-1:0];

endmodule

@@ design/nnds_checker.sv @@
module nnds_checker #(
    parameter int MAX_DST_WIDTH  = nnds_pkg::MAX_DST_WIDTH_DEF,
    parameter int MAX_DST_HEIGHT = nnds_pkg::MAX_DST_HEIGHT_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic                          pready,
    input logic [nnds_pkg::PADDR_W-1:0]  paddr,
    input logic [nnds_pkg::PDATA_W-1:0]  pwdata,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [nnds_pkg::PIX_W-1:0]    out_pixel,
    input logic [nnds_pkg::DEST_W-1:0]   dest_x,
    input logic [nnds_pkg::DEST_W-1:0]   dest_y,
    input logic                          frame_end
);

    logic [nnds_pkg::DST_CFG_W-1:0] dw_shadow_reg, dh_shadow_reg;
    logic [nnds_pkg::REG_IDX_W-1:0] wr_idx;
    logic                           cfg_acc;
    logic                           size_wr;
    logic [31:0]                    dw_lim, dh_lim;

    assign wr_idx  = paddr[nnds_pkg::PADDR_W-1:2];
    assign cfg_acc = psel && penable && pwrite && pready;
    assign size_wr = cfg_acc && (wr_idx == nnds_pkg::REG_SRC_WIDTH
                              || wr_idx == nnds_pkg::REG_SRC_HEIGHT
                              || wr_idx == nnds_pkg::REG_DST_WIDTH
                              || wr_idx == nnds_pkg::REG_DST_HEIGHT);

    // Shadow of the destination sizes seen on the bus
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dw_shadow_reg <= nnds_pkg::DST_WIDTH_RST;
            dh_shadow_reg <= nnds_pkg::DST_HEIGHT_RST;
        end
        else if (cfg_acc && wr_idx == nnds_pkg::REG_DST_WIDTH)
        begin
            dw_shadow_reg <= pwdata[nnds_pkg::DST_CFG_W-1:0];
        end
        else if (cfg_acc && wr_idx == nnds_pkg::REG_DST_HEIGHT)
        begin
            dh_shadow_reg <= pwdata[nnds_pkg::DST_CFG_W-1:0];
        end
    end

    // Effective limits: zero acts as one, saturate at the build maximum
    always_comb
    begin
        dw_lim = (dw_shadow_reg == '0) ? 32'd1 : 32'(dw_shadow_reg);
        dh_lim = (dh_shadow_reg == '0) ? 32'd1 : 32'(dh_shadow_reg);
        if (dw_lim > 32'(MAX_DST_WIDTH))
            dw_lim = 32'(MAX_DST_WIDTH);
        if (dh_lim > 32'(MAX_DST_HEIGHT))
            dh_lim = 32'(MAX_DST_HEIGHT);
    end

    // Output word held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_pixel) && $stable(dest_x)
                                    && $stable(dest_y) && $stable(frame_end))
        else $error("output word changed while stalled");

    // A size write starts a map rebuild, so input must pause
    a_rebuild_stall: assert property (@(posedge clk) disable iff (!rst_n)
        size_wr |=> !in_ready)
        else $error("input ready right after a size write");

    // Destination coordinates stay inside the configured frame
    a_dest_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(dest_x) < dw_lim) && (32'(dest_y) < dh_lim))
        else $error("destination coordinate outside the frame");

endmodule

bind nearest_neighbor_frame_downscaler_core nnds_checker #(
    .MAX_DST_WIDTH  (MAX_DST_WIDTH),
    .MAX_DST_HEIGHT (MAX_DST_HEIGHT)
) u_nnds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .in_ready  (pixel_in.ready),
    .out_valid (pixel_out.valid),
    .out_ready (pixel_out.ready),
    .out_pixel (pixel_out.out_pixel),
    .dest_x    (pixel_out.dest_x),
    .dest_y    (pixel_out.dest_y),
    .frame_end (pixel_out.frame_end)
);

@@ verif/tb_nearest_neighbor_frame_downscaler_core.sv @@
module tb_nearest_neighbor_frame_downscaler_core;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int FINAL_GUARD  = 20000;
    localparam int LONG_HOLD    = 400;
    localparam int TIMEOUT_TIME = 10_000_000;

    // One scaled pixel word as seen on pixel_out
    typedef struct packed {
        logic [nnds_pkg::PIX_W-1:0]  out_pixel;
        logic [nnds_pkg::DEST_W-1:0] dest_x;
        logic [nnds_pkg::DEST_W-1:0] dest_y;
        logic                        frame_end;
    } scaled_pixel_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [nnds_pkg::PADDR_W-1:0]  paddr;
    logic [nnds_pkg::PDATA_W-1:0]  pwdata;
    logic [nnds_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    nnds_in_if  pixel_in_bus ();
    nnds_out_if pixel_out_bus ();

    nearest_neighbor_frame_downscaler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pixel_in  (pixel_in_bus),
        .pixel_out (pixel_out_bus)
    );

    // Register shadow
    logic [nnds_pkg::SRC_CFG_W-1:0] cfg_src_w;
    logic [nnds_pkg::SRC_CFG_W-1:0] cfg_src_h;
    logic [nnds_pkg::DST_CFG_W-1:0] cfg_dst_w;
    logic [nnds_pkg::DST_CFG_W-1:0] cfg_dst_h;
    logic                           cfg_swap;

    // Scan position and selection tracking
    logic [10:0] src_col;
    logic [10:0] src_row;
    logic [7:0]  next_dest_col;
    logic [10:0] next_sel_col;
    logic [7:0]  next_dest_row;
    logic [10:0] next_sel_row;

    scaled_pixel_t pending_pixels[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int hold_until     = 0;
    int failures       = 0;
    int words_sent     = 0;
    int words_checked  = 0;
    int size_settings  = 0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scaler prediction
    // ------------------------------------------------------------------

    // zero acts as one, oversize saturates
    function automatic int unsigned eff_size(input int unsigned v, input int unsigned cap);
        if (v == 0)
            return 1;
        return (v > cap) ? cap : v;
    endfunction

    // ceil(a*b/c), capped
    function automatic int unsigned ceil_capped(input int unsigned a, input int unsigned b,
                                                input int unsigned c, input int unsigned cap);
        int unsigned q;
        q = (a * b + c - 1) / c;
        return (q > cap) ? cap : q;
    endfunction

    function automatic void restart_frame();
        src_col       = '0;
        src_row       = '0;
        next_dest_col = '0;
        next_sel_col  = '0;
        next_dest_row = '0;
        next_sel_row  = '0;
    endfunction

    function automatic void predict_scaled(input logic [nnds_pkg::PIX_W-1:0] pix, input logic fs);
        int unsigned w, h, dw, dh, row_next, d, sel;
        logic row_hit, col_hit;
        scaled_pixel_t px;
        w  = eff_size(32'(cfg_src_w), nnds_pkg::MAX_SRC_SIZE_DEF);
        h  = eff_size(32'(cfg_src_h), nnds_pkg::MAX_SRC_SIZE_DEF);
        dw = eff_size(32'(cfg_dst_w), nnds_pkg::MAX_DST_WIDTH_DEF);
        dh = eff_size(32'(cfg_dst_h), nnds_pkg::MAX_DST_HEIGHT_DEF);
        if (fs)
            restart_frame();
        row_hit  = (next_dest_row < dh) && (src_row == next_sel_row);
        col_hit  = (next_dest_col < dw) && (src_col == next_sel_col);
        row_next = ceil_capped(src_row + 1, dh, h, dh);
        // selected pixel: emit it and advance the column selection
        if (row_hit && col_hit)
        begin
            d = ceil_capped(src_col + 1, dw, w, dw);
            px.out_pixel = cfg_swap ? {pix[7:0], pix[15:8]} : pix;
            px.dest_x    = next_dest_col;
            px.dest_y    = next_dest_row;
            px.frame_end = (d >= dw) && (row_next >= dh);
            pending_pixels.push_back(px);
            next_dest_col = d[7:0];
            sel = d * w / dw;
            next_sel_col = sel[10:0];
        end
        // end of source line: advance row selection, wrap at end of frame
        if (src_col + 1 >= w)
        begin
            src_col       = '0;
            next_dest_col = '0;
            next_sel_col  = '0;
            if (row_hit)
            begin
                next_dest_row = row_next[7:0];
                sel = row_next * h / dh;
                next_sel_row = sel[10:0];
            end
            if (src_row + 1 >= h)
                restart_frame();
            else
                src_row = src_row + 11'd1;
        end
        else
        begin
            src_col = src_col + 11'd1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random ready, long hold-off, word check
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_sink
        scaled_pixel_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (pixel_out_bus.valid && pixel_out_bus.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("unexpected output word: out_pixel %h dest_x %0d dest_y %0d",
                           pixel_out_bus.out_pixel, pixel_out_bus.dest_x, pixel_out_bus.dest_y);
                    failures++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    words_checked++;
                    if (pixel_out_bus.out_pixel !== want.out_pixel)
                    begin
                        $error("out_pixel mismatch: expected %h, actual %h",
                               want.out_pixel, pixel_out_bus.out_pixel);
                        failures++;
                    end
                    if (pixel_out_bus.dest_x !== want.dest_x)
                    begin
                        $error("dest_x mismatch: expected %0d, actual %0d",
                               want.dest_x, pixel_out_bus.dest_x);
                        failures++;
                    end
                    if (pixel_out_bus.dest_y !== want.dest_y)
                    begin
                        $error("dest_y mismatch: expected %0d, actual %0d",
                               want.dest_y, pixel_out_bus.dest_y);
                        failures++;
                    end
                    if (pixel_out_bus.frame_end !== want.frame_end)
                    begin
                        $error("frame_end mismatch: expected %0d, actual %0d",
                               want.frame_end, pixel_out_bus.frame_end);
                        failures++;
                    end
                end
            end
            if (cycle_count < hold_until)
                pixel_out_bus.ready <= 1'b0;
            else
                pixel_out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        else
        begin
            pixel_out_bus.ready <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Source side and register access
    // ------------------------------------------------------------------

    // offer one source word, return at the edge where it is taken
    task automatic send_word(input logic [nnds_pkg::PIX_W-1:0] pix, input logic fs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_in_bus.valid       <= 1'b1;
        pixel_in_bus.src_pixel   <= pix;
        pixel_in_bus.frame_start <= fs;
        @(posedge clk);
        while (!pixel_in_bus.ready)
            @(posedge clk);
        words_sent++;
        predict_scaled(pix, fs);
    endtask

    // random pixels; start mark on the first word, noise starts on the rest
    task automatic send_run(input int count, input logic first_start, input int start_pct);
        logic [31:0] rnd;
        for (int k = 0; k < count; k++)
        begin
            rnd = $urandom;
            send_word(rnd[nnds_pkg::PIX_W-1:0],
                      (k == 0) ? first_start : ($urandom_range(99) < start_pct));
        end
    endtask

    task automatic wait_for_drain();
        pixel_in_bus.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup then access phase
    task automatic write_reg(input logic [nnds_pkg::REG_IDX_W-1:0] idx,
                             input logic [nnds_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            nnds_pkg::REG_SRC_WIDTH:  cfg_src_w = value[nnds_pkg::SRC_CFG_W-1:0];
            nnds_pkg::REG_SRC_HEIGHT: cfg_src_h = value[nnds_pkg::SRC_CFG_W-1:0];
            nnds_pkg::REG_DST_WIDTH:  cfg_dst_w = value[nnds_pkg::DST_CFG_W-1:0];
            nnds_pkg::REG_DST_HEIGHT: cfg_dst_h = value[nnds_pkg::DST_CFG_W-1:0];
            nnds_pkg::REG_SWAP_BYTES: cfg_swap  = value[0];
            default: ;
        endcase
    endtask

    // only touched once the block has gone quiet
    task automatic set_sizes(input int sw, input int sh, input int dw, input int dh,
                             input logic swap);
        wait_for_drain();
        write_reg(nnds_pkg::REG_SRC_WIDTH, sw);
        write_reg(nnds_pkg::REG_SRC_HEIGHT, sh);
        write_reg(nnds_pkg::REG_DST_WIDTH, dw);
        write_reg(nnds_pkg::REG_DST_HEIGHT, dh);
        write_reg(nnds_pkg::REG_SWAP_BYTES, {31'd0, swap});
        size_settings++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // default 320x240 -> 240x240 with swap, first line and a bit of the next
    task automatic test_reset_defaults();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_run(330, 1'b1, 0);
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // 3x2 onto 2x1 with swap, pixel bit extremes
        set_sizes(3, 2, 2, 1, 1'b1);
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h00FF, 1'b0);
        send_word(16'hFF00, 1'b0);
        send_word(16'h5A3C, 1'b0);
        send_word(16'hA5C3, 1'b0);
        // no start mark: position wraps past the frame end
        send_word(16'h1234, 1'b0);
        send_word(16'h4321, 1'b0);
        // start mark at the end of a line
        send_word(16'hBEEF, 1'b1);
        send_word(16'hCAFE, 1'b0);
        // upscaling leaves out repeats, swap off
        set_sizes(2, 2, 4, 4, 1'b0);
        send_word(16'h0001, 1'b1);
        send_word(16'h8000, 1'b0);
        send_word(16'h7FFE, 1'b0);
        send_word(16'hFFFF, 1'b0);
        // sizes change mid-frame; column now past the new width
        set_sizes(4, 2, 2, 2, 1'b1);
        send_word(16'h1357, 1'b1);
        send_word(16'h2468, 1'b0);
        set_sizes(2, 2, 1, 2, 1'b1);
        send_word(16'h9ABC, 1'b0);
        send_word(16'hDEF0, 1'b0);
        send_word(16'h0F0F, 1'b0);
        send_word(16'hF0F0, 1'b0);
    endtask

    // widest and tallest sources partly walked, full-width frame end
    task automatic test_size_extremes();
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        set_sizes(nnds_pkg::MAX_SRC_SIZE_DEF, 1, nnds_pkg::MAX_DST_WIDTH_DEF, 1, 1'b1);
        send_run(128, 1'b1, 0);
        set_sizes(1, nnds_pkg::MAX_SRC_SIZE_DEF, 1, nnds_pkg::MAX_DST_HEIGHT_DEF, 1'b0);
        send_run(128, 1'b1, 0);
        set_sizes(nnds_pkg::MAX_DST_WIDTH_DEF, 1, nnds_pkg::MAX_DST_WIDTH_DEF, 1, 1'b1);
        send_run(nnds_pkg::MAX_DST_WIDTH_DEF, 1'b1, 0);
        set_sizes(1, 1, 1, 1, 1'b0);
        send_run(4, 1'b0, 0);
        set_sizes(1, 1, nnds_pkg::MAX_DST_WIDTH_DEF, nnds_pkg::MAX_DST_HEIGHT_DEF, 1'b1);
        send_run(4, 1'b1, 50);
    endtask

    // receiver holds off while a 1:1 frame keeps coming, then a drained restart
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_sizes(8, 8, 8, 8, 1'b1);
        hold_until = cycle_count + LONG_HOLD;
        send_run(64, 1'b1, 0);
        wait_for_drain();
        send_run(64, 1'b1, 0);
    endtask

    task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                      input int item_count);
        int first_word, sw, sh, dw, dh, area;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first_word = words_sent;
        while (words_sent - first_word < item_count)
        begin
            sw = $urandom_range(24, 1);
            sh = $urandom_range(12, 1);
            dw = ($urandom_range(3) == 0) ? $urandom_range(32, 1) : $urandom_range(sw, 1);
            dh = ($urandom_range(3) == 0) ? $urandom_range(20, 1) : $urandom_range(sh, 1);
            area = sw * sh;
            set_sizes(sw, sh, dw, dh, 1'($urandom_range(1)));
            repeat ($urandom_range(3, 1))
            begin
                case ($urandom_range(9))
                    0, 1: send_run($urandom_range(area, 1), 1'b1, 0);  // cut short
                    2: send_run(area, 1'b0, 0);                        // no start mark
                    3: send_run(area, 1'b1, 8);                        // stray starts
                    default: send_run(area, 1'b1, 0);
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------
    initial
    begin : run_all
        int guard;
        rst_n                    = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        pixel_in_bus.valid       = 1'b0;
        pixel_in_bus.src_pixel   = '0;
        pixel_in_bus.frame_start = 1'b0;
        cfg_src_w = nnds_pkg::SRC_WIDTH_RST;
        cfg_src_h = nnds_pkg::SRC_HEIGHT_RST;
        cfg_dst_w = nnds_pkg::DST_WIDTH_RST;
        cfg_dst_h = nnds_pkg::DST_HEIGHT_RST;
        cfg_swap  = nnds_pkg::SWAP_BYTES_RST;
        restart_frame();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed();
        test_size_extremes();
        test_backpressure();
        test_random_frames(0, 0, 60);
        test_random_frames(58, 0, 60);
        test_random_frames(0, 58, 60);
        test_random_frames(33, 33, 60);

        // let the tail drain, bounded
        pixel_in_bus.valid <= 1'b0;
        for (guard = 0; guard < FINAL_GUARD && pending_pixels.size() != 0; guard++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            $error("%0d scaled words never came out", pending_pixels.size());
            failures++;
        end

        $display("sent %0d source words, checked %0d scaled words over %0d size settings",
                 words_sent, words_checked, size_settings);
        $display("covered defaults, size extremes, upscaling, wrap, stray starts, backpressure");
        if (failures == 0)
            $display("nearest_neighbor_frame_downscaler_core regression: pass");
        else
            $display("nearest_neighbor_frame_downscaler_core regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        #TIMEOUT_TIME;
        $display("nearest_neighbor_frame_downscaler_core regression: fail");
        $finish;
    end

endmodule
